/* src/cabt_pkg.sv */
// cabt_pkg: shared types, field widths, command and status codes and FSM states
// for the checkpointed active bound trail block.
// No dependencies; every other file of the block imports this package.
package cabt_pkg;

  // Fixed field widths of the item and result beats
  localparam int CMD_W       = 4;
  localparam int GEN_W       = 16;
  localparam int BIDX_W      = 10;
  localparam int AIDX_W      = 9;
  localparam int CKPT_W      = 16;
  localparam int STATUS_W    = 2;
  localparam int TRAIL_CNT_W = 11;
  localparam int LEVEL_CNT_W = 7;

  // Default capacities
  localparam int DEF_MAX_BOUNDS = 1024;
  localparam int DEF_MAX_ATOMS  = 512;
  localparam int DEF_MAX_LEVELS = 64;

  // Generation tag after reset
  localparam logic [GEN_W-1:0] GEN_RESET = 16'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_REG_BOUND   = 4'd0,
    CMD_REG_ATOM    = 4'd1,
    CMD_PUSH        = 4'd2,
    CMD_ACTIVATE    = 4'd3,
    CMD_POP         = 4'd4,
    CMD_SET_PENDING = 4'd5,
    CMD_CLR_PENDING = 4'd6,
    CMD_QUERY_BOUND = 4'd7,
    CMD_QUERY_ATOM  = 4'd8
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_CKPT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_ATOM,
    S_EVAL,
    S_SEARCH,
    S_CHECK,
    S_WALK,
    S_COMMIT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic lookup;
    logic atom_rd;
    logic eval;
    logic search_step;
    logic walk_init;
    logic walk_step;
    logic pop_commit;
    logic pop_fail;
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_pop;
    logic is_qatom;
    logic search_end;
    logic tag_hit;
    logic walk_done;
    logic slot_free;
  } sts_t;

endpackage

/* src/cabt_if.sv */
// cabt_if: valid/ready channel interfaces for item, result and configuration beats.
// Depends on cabt_pkg for field widths.

interface cabt_item_if import cabt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [GEN_W-1:0]  item_generation;
  logic [BIDX_W-1:0] bound_index;
  logic [AIDX_W-1:0] atom_index;
  logic [BIDX_W-1:0] pos_lit_bound;
  logic [BIDX_W-1:0] neg_lit_bound;
  logic [CKPT_W-1:0] checkpoint_id;

  modport source(output valid, command, item_generation, bound_index, atom_index,
                 pos_lit_bound, neg_lit_bound, checkpoint_id, input ready);
  modport sink(input valid, command, item_generation, bound_index, atom_index,
               pos_lit_bound, neg_lit_bound, checkpoint_id, output ready);
endinterface

interface cabt_result_if import cabt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic                   bound_active;
  logic                   polarity_known;
  logic                   polarity_positive;
  logic [TRAIL_CNT_W-1:0] trail_count;
  logic [LEVEL_CNT_W-1:0] level_total;

  modport source(output valid, status, bound_active, polarity_known, polarity_positive,
                 trail_count, level_total, input ready);
  modport sink(input valid, status, bound_active, polarity_known, polarity_positive,
               trail_count, level_total, output ready);
endinterface

interface cabt_cfg_if import cabt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [GEN_W-1:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

/* src/cabt_ctrl.sv */
// cabt_ctrl: sequencing FSM; issues datapath commands per item and runs the pop
// search and trail unwind loops. Depends on cabt_pkg.

module cabt_ctrl import cabt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_e state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_LOOKUP;
      S_LOOKUP: begin
        if (sts.is_pop)        state_next = S_SEARCH;
        else if (sts.is_qatom) state_next = S_ATOM;
        else                   state_next = S_EVAL;
      end
      S_ATOM:   state_next = S_EVAL;
      S_EVAL:   if (sts.slot_free) state_next = S_IDLE;
      S_SEARCH: begin
        if (!sts.search_end)    state_next = S_CHECK;
        else if (sts.slot_free) state_next = S_IDLE;
      end
      S_CHECK:  state_next = sts.tag_hit ? S_WALK : S_SEARCH;
      S_WALK:   if (sts.walk_done) state_next = S_COMMIT;
      S_COMMIT: if (sts.slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      S_LOOKUP: ctl.lookup  = 1'b1;
      S_ATOM:   ctl.atom_rd = 1'b1;
      S_EVAL:   ctl.eval    = sts.slot_free;
      S_SEARCH: begin
        ctl.search_step = !sts.search_end;
        ctl.pop_fail    = sts.search_end && sts.slot_free;
      end
      S_CHECK:  ctl.walk_init  = sts.tag_hit;
      S_WALK:   ctl.walk_step  = 1'b1;
      S_COMMIT: ctl.pop_commit = sts.slot_free;
      default:  ctl = '0;
    endcase
  end

endmodule

/* src/cabt_dp.sv */
// cabt_dp: datapath with counters, pending bound, membership/trail/atom/level
// memories, evaluation logic and the result register. Depends on cabt_pkg.

module cabt_dp import cabt_pkg::*; #(
  parameter int MAX_BOUNDS = DEF_MAX_BOUNDS,
  parameter int MAX_ATOMS  = DEF_MAX_ATOMS,
  parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctl_t                   ctl,
  output sts_t                   sts,
  // configuration
  input  logic                   cfg_we,
  input  logic [GEN_W-1:0]       cfg_data,
  // item fields
  input  logic [CMD_W-1:0]       command,
  input  logic [GEN_W-1:0]       item_generation,
  input  logic [BIDX_W-1:0]      bound_index,
  input  logic [AIDX_W-1:0]      atom_index,
  input  logic [BIDX_W-1:0]      pos_lit_bound,
  input  logic [BIDX_W-1:0]      neg_lit_bound,
  input  logic [CKPT_W-1:0]      checkpoint_id,
  // result beat
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [STATUS_W-1:0]    res_status,
  output logic                   res_bound_active,
  output logic                   res_polarity_known,
  output logic                   res_polarity_positive,
  output logic [TRAIL_CNT_W-1:0] res_trail_count,
  output logic [LEVEL_CNT_W-1:0] res_level_total
);

  localparam int BAW = (MAX_BOUNDS > 1) ? $clog2(MAX_BOUNDS) : 1;
  localparam int BCW = $clog2(MAX_BOUNDS + 1);
  localparam int AAW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int ACW = $clog2(MAX_ATOMS + 1);
  localparam int LAW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int LCW = $clog2(MAX_LEVELS + 1);
  localparam int AEW = 2 * BIDX_W;
  localparam int LEW = CKPT_W + BCW;

  // Latched item
  logic [CMD_W-1:0]  cmd_q;
  logic [GEN_W-1:0]  gen_q;
  logic [BIDX_W-1:0] bidx_q;
  logic [AIDX_W-1:0] aidx_q;
  logic [BIDX_W-1:0] pos_q, neg_q;
  logic [CKPT_W-1:0] ckpt_q;

  // Control state
  logic [GEN_W-1:0]  own_generation;
  logic [BCW-1:0]    bound_total;
  logic [ACW-1:0]    atom_total;
  logic [BCW-1:0]    trail_size;
  logic [LCW-1:0]    level_size;
  logic              pending_valid;
  logic [BIDX_W-1:0] pending_bound;
  logic [LCW-1:0]    lv;
  logic [BCW-1:0]    walk_ptr;
  logic [BCW-1:0]    mark;
  logic              wr_pend;

  // Memories and their read registers
  logic              member_mem [MAX_BOUNDS];
  logic [BIDX_W-1:0] trail_mem  [MAX_BOUNDS];
  logic [AEW-1:0]    atom_mem   [MAX_ATOMS];
  logic [LEW-1:0]    level_mem  [MAX_LEVELS];
  logic              rd_a, rd_b;
  logic [BIDX_W-1:0] trail_rd;
  logic [AEW-1:0]    atom_rd;
  logic [LEW-1:0]    level_rd;

  // Evaluation results
  logic [STATUS_W-1:0] ev_status;
  logic              ev_act, ev_known, ev_pos;
  logic              bt_inc, at_inc, lvl_push, tr_push, pend_set, pend_clr;
  logic              bit_we, bit_val;
  logic [BAW-1:0]    bit_addr;
  logic              own, bidx_known, bidx_active, pos_active, neg_active;
  logic [BIDX_W-1:0] apos, aneg;
  logic              load_res;

  assign own        = (gen_q == own_generation);
  assign bidx_known = own && (32'(bidx_q) < 32'(bound_total));
  assign bidx_active = (bidx_known && rd_a) ||
                       (pending_valid && own && pending_bound == bidx_q);
  assign apos       = atom_rd[AEW-1:BIDX_W];
  assign aneg       = atom_rd[BIDX_W-1:0];
  assign pos_active = ((32'(apos) < 32'(bound_total)) && rd_a) ||
                      (pending_valid && pending_bound == apos);
  assign neg_active = ((32'(aneg) < 32'(bound_total)) && rd_b) ||
                      (pending_valid && pending_bound == aneg);

  // Status toward the controller
  assign sts.is_pop     = (cmd_q == CMD_POP);
  assign sts.is_qatom   = (cmd_q == CMD_QUERY_ATOM);
  assign sts.search_end = !own || (lv == '0);
  assign sts.tag_hit    = (level_rd[LEW-1:BCW] == ckpt_q);
  assign sts.walk_done  = !(walk_ptr > mark) && !wr_pend;
  assign sts.slot_free  = !res_valid || res_ready;

  assign load_res = ctl.eval || ctl.pop_commit || ctl.pop_fail;

  // Per-command evaluation once the memory reads are in
  always_comb begin
    ev_status = ST_OK;
    ev_act    = 1'b0;
    ev_known  = 1'b0;
    ev_pos    = 1'b0;
    bt_inc    = 1'b0;
    at_inc    = 1'b0;
    lvl_push  = 1'b0;
    tr_push   = 1'b0;
    pend_set  = 1'b0;
    pend_clr  = 1'b0;
    bit_we    = 1'b0;
    bit_val   = 1'b0;
    bit_addr  = BAW'(bidx_q);
    unique case (cmd_q)
      CMD_REG_BOUND: begin
        priority if (!own)                                    ev_status = ST_INVALID;
        else if (32'(bound_total) >= 32'(MAX_BOUNDS))         ev_status = ST_FULL;
        else if (32'(bidx_q) != 32'(bound_total))             ev_status = ST_INVALID;
        else begin
          bt_inc   = 1'b1;
          bit_we   = 1'b1;
          bit_addr = BAW'(bound_total);
        end
      end
      CMD_REG_ATOM: begin
        priority if (!own)                                    ev_status = ST_INVALID;
        else if (32'(atom_total) >= 32'(MAX_ATOMS))           ev_status = ST_FULL;
        else if (32'(aidx_q) != 32'(atom_total))              ev_status = ST_INVALID;
        else                                                  at_inc = 1'b1;
      end
      CMD_PUSH: begin
        priority if (!own || ckpt_q == '0)                    ev_status = ST_BAD_CKPT;
        else if (32'(level_size) >= 32'(MAX_LEVELS))          ev_status = ST_FULL;
        else                                                  lvl_push = 1'b1;
      end
      CMD_ACTIVATE: begin
        priority if (!bidx_known || bidx_active)              ev_status = ST_INVALID;
        else if (32'(trail_size) >= 32'(MAX_BOUNDS))          ev_status = ST_FULL;
        else begin
          tr_push = 1'b1;
          bit_we  = 1'b1;
          bit_val = 1'b1;
        end
      end
      CMD_SET_PENDING: begin
        if (!bidx_known || bidx_active) ev_status = ST_INVALID;
        else                            pend_set = 1'b1;
      end
      CMD_CLR_PENDING: pend_clr = 1'b1;
      CMD_QUERY_BOUND: ev_act = bidx_active;
      CMD_QUERY_ATOM: begin
        priority if (!own || 32'(aidx_q) >= 32'(atom_total)) ev_status = ST_INVALID;
        else if (pos_active) begin
          ev_known = 1'b1;
          ev_pos   = 1'b1;
        end else if (neg_active) begin
          ev_known = 1'b1;
        end
      end
      default: ev_status = ST_INVALID;
    endcase
  end

  // Item latch, counters, pop walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_generation <= GEN_RESET;
      bound_total    <= '0;
      atom_total     <= '0;
      trail_size     <= '0;
      level_size     <= '0;
      pending_valid  <= 1'b0;
      pending_bound  <= '0;
      lv             <= '0;
      walk_ptr       <= '0;
      mark           <= '0;
      wr_pend        <= 1'b0;
    end else begin
      if (cfg_we) own_generation <= cfg_data;
      if (ctl.load) lv <= level_size;
      if (ctl.eval) begin
        if (bt_inc)   bound_total <= bound_total + BCW'(1);
        if (at_inc)   atom_total  <= atom_total + ACW'(1);
        if (lvl_push) level_size  <= level_size + LCW'(1);
        if (tr_push)  trail_size  <= trail_size + BCW'(1);
        if (pend_set) begin
          pending_valid <= 1'b1;
          pending_bound <= bidx_q;
        end else if (pend_clr) begin
          pending_valid <= 1'b0;
          pending_bound <= '0;
        end
      end
      if (ctl.search_step) lv <= lv - LCW'(1);
      if (ctl.walk_init) begin
        mark     <= level_rd[BCW-1:0];
        walk_ptr <= trail_size;
        wr_pend  <= 1'b0;
      end
      // Unwind: read one trail entry per cycle, clear its bit the next cycle
      if (ctl.walk_step) begin
        if (walk_ptr > mark) begin
          walk_ptr <= walk_ptr - BCW'(1);
          wr_pend  <= 1'b1;
        end else begin
          wr_pend  <= 1'b0;
        end
      end
      if (ctl.pop_commit) begin
        if (mark < trail_size) trail_size <= mark;
        level_size    <= lv;
        pending_valid <= 1'b0;
        pending_bound <= '0;
      end
    end
  end

  // Item payload latch
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= command;
      gen_q  <= item_generation;
      bidx_q <= bound_index;
      aidx_q <= atom_index;
      pos_q  <= pos_lit_bound;
      neg_q  <= neg_lit_bound;
      ckpt_q <= checkpoint_id;
    end
  end

  // Membership bits: two read ports, one write port
  always_ff @(posedge clk) begin
    if (ctl.lookup) rd_a <= member_mem[BAW'(bidx_q)];
    if (ctl.atom_rd) begin
      rd_a <= member_mem[BAW'(apos)];
      rd_b <= member_mem[BAW'(aneg)];
    end
    if (wr_pend)                    member_mem[BAW'(trail_rd)] <= 1'b0;
    else if (ctl.eval && bit_we)    member_mem[bit_addr] <= bit_val;
  end

  // Trail store
  always_ff @(posedge clk) begin
    if (ctl.walk_step && walk_ptr > mark) trail_rd <= trail_mem[BAW'(walk_ptr - BCW'(1))];
    if (ctl.eval && tr_push) trail_mem[BAW'(trail_size)] <= bidx_q;
  end

  // Atom store
  always_ff @(posedge clk) begin
    if (ctl.lookup) atom_rd <= atom_mem[AAW'(aidx_q)];
    if (ctl.eval && at_inc) atom_mem[AAW'(atom_total)] <= {pos_q, neg_q};
  end

  // Level stack
  always_ff @(posedge clk) begin
    if (ctl.search_step) level_rd <= level_mem[LAW'(lv - LCW'(1))];
    if (ctl.eval && lvl_push) level_mem[LAW'(level_size)] <= {ckpt_q, trail_size};
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      res_status            <= ev_status;
      res_bound_active      <= ev_act;
      res_polarity_known    <= ev_known;
      res_polarity_positive <= ev_pos;
      res_trail_count       <= TRAIL_CNT_W'(tr_push ? trail_size + BCW'(1) : trail_size);
      res_level_total       <= LEVEL_CNT_W'(lvl_push ? level_size + LCW'(1) : level_size);
    end else if (ctl.pop_commit || ctl.pop_fail) begin
      res_status            <= ctl.pop_fail ? ST_BAD_CKPT : ST_OK;
      res_bound_active      <= 1'b0;
      res_polarity_known    <= 1'b0;
      res_polarity_positive <= 1'b0;
      res_trail_count       <= TRAIL_CNT_W'((ctl.pop_commit && mark < trail_size) ?
                                            mark : trail_size);
      res_level_total       <= LEVEL_CNT_W'(ctl.pop_commit ? lv : level_size);
    end
  end

endmodule

/* src/checkpointed_active_bound_trail.sv */
// checkpointed_active_bound_trail: top level joining controller and datapath.
// Depends on cabt_pkg, cabt_if, cabt_ctrl, cabt_dp.
//
//   channel  | modport | beat carries
//   ---------+---------+------------------------------------------------
//   item     | sink    | command, generation, bound/atom ordinals, ckpt
//   result   | source  | status, activity, polarity, trail/level counts
//   cfg      | sink    | own_generation write data (always ready)
//
// One item at a time: most commands pass lookup and evaluation; an atom
// query adds a membership read after the atom store read. A pop searches
// the level stack and, on a tag hit, unwinds the trail entries above that
// level's mark before it commits; a miss reports a bad checkpoint. Reset is
// synchronous and needs no clearing pass. A stalled result holds in the
// output register; the next item is accepted meanwhile and waits for it.

module checkpointed_active_bound_trail import cabt_pkg::*; #(
  parameter int MAX_BOUNDS = DEF_MAX_BOUNDS,
  parameter int MAX_ATOMS  = DEF_MAX_ATOMS,
  parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
  input logic           clk,
  input logic           rst,
  cabt_item_if.sink     item,
  cabt_result_if.source result,
  cabt_cfg_if.sink      cfg
);

  ctl_t ctl;
  sts_t sts;

  assign cfg.ready = 1'b1;

  cabt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  cabt_dp #(
    .MAX_BOUNDS (MAX_BOUNDS),
    .MAX_ATOMS  (MAX_ATOMS),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .ctl                   (ctl),
    .sts                   (sts),
    .cfg_we                (cfg.valid),
    .cfg_data              (cfg.data),
    .command               (item.command),
    .item_generation       (item.item_generation),
    .bound_index           (item.bound_index),
    .atom_index            (item.atom_index),
    .pos_lit_bound         (item.pos_lit_bound),
    .neg_lit_bound         (item.neg_lit_bound),
    .checkpoint_id         (item.checkpoint_id),
    .res_valid             (result.valid),
    .res_ready             (result.ready),
    .res_status            (result.status),
    .res_bound_active      (result.bound_active),
    .res_polarity_known    (result.polarity_known),
    .res_polarity_positive (result.polarity_positive),
    .res_trail_count       (result.trail_count),
    .res_level_total       (result.level_total)
  );

endmodule

/* src/cabt_checker.sv */
// cabt_checker: port-level assertions for the trail block, bound to the top.
// Depends on cabt_pkg and checkpointed_active_bound_trail.

module cabt_checker import cabt_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [STATUS_W-1:0]    status,
  input logic                   bound_active,
  input logic                   polarity_known,
  input logic                   polarity_positive,
  input logic [TRAIL_CNT_W-1:0] trail_count
);

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(trail_count))
    else $error("result beat changed while stalled");

  // No result right after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Bound activity only reported with ok status
  a_act: assert property (@(posedge clk) disable iff (rst)
    out_valid && bound_active |-> status == ST_OK)
    else $error("bound_active with error status");

  // Positive polarity implies known polarity, known only with ok status
  a_pol: assert property (@(posedge clk) disable iff (rst)
    out_valid && (polarity_positive || polarity_known) |->
      polarity_known && status == ST_OK)
    else $error("inconsistent polarity bits");

endmodule

bind checkpointed_active_bound_trail cabt_checker u_cabt_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (result.valid),
  .out_ready         (result.ready),
  .status            (result.status),
  .bound_active      (result.bound_active),
  .polarity_known    (result.polarity_known),
  .polarity_positive (result.polarity_positive),
  .trail_count       (result.trail_count)
);

/* sim/tb_checkpointed_active_bound_trail.sv */
// Testbench for checkpointed_active_bound_trail: directed table then random
// solver-like traffic, each result beat checked against a behavioral trail model.
// Depends on cabt_pkg, cabt_if and the block's RTL.
module tb_checkpointed_active_bound_trail import cabt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_BOUNDS = DEF_MAX_BOUNDS;
  localparam int N_ATOMS  = DEF_MAX_ATOMS;
  localparam int N_LEVELS = DEF_MAX_LEVELS;
  localparam int N_RANDOM = 1600;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 2200;

  typedef struct packed {
    cmd_e              command;
    logic [GEN_W-1:0]  gen;
    logic [BIDX_W-1:0] bidx;
    logic [AIDX_W-1:0] aidx;
    logic [BIDX_W-1:0] pos;
    logic [BIDX_W-1:0] neg;
    logic [CKPT_W-1:0] ckpt;
  } item_t;

  typedef struct packed {
    status_e                status;
    logic                   act;
    logic                   known;
    logic                   positive;
    logic [TRAIL_CNT_W-1:0] trail;
    logic [LEVEL_CNT_W-1:0] levels;
  } res_t;

  // One directed row: the item plus an optional typed-in expectation
  typedef struct packed {
    item_t it;
    logic  has_exp;
    res_t  exp;
  } row_t;

  logic clk;
  logic rst;
  cabt_item_if   item_ch();
  cabt_result_if res_ch();
  cabt_cfg_if    cfg_ch();

  checkpointed_active_bound_trail u_dut (
    .clk(clk), .rst(rst), .item(item_ch.sink), .result(res_ch.source), .cfg(cfg_ch.sink)
  );

  // Trail model state
  logic [GEN_W-1:0]  m_gen;
  int unsigned       m_bounds, m_atoms, m_trail, m_levels;
  logic [BIDX_W-1:0] m_apos [N_ATOMS];
  logic [BIDX_W-1:0] m_aneg [N_ATOMS];
  bit                m_member [N_BOUNDS];
  logic [BIDX_W-1:0] m_trail_ent [N_BOUNDS];
  logic [CKPT_W-1:0] m_ltag [N_LEVELS];
  int unsigned       m_lmark [N_LEVELS];
  bit                m_pend_v;
  logic [BIDX_W-1:0] m_pend_b;

  res_t expected_q[$];
  row_t dir_tab[$];
  int   mismatches;
  int   idle_pct;
  bit   hold_off;
  int   quiet;
  bit   timed_out;

  function automatic bit bound_known(logic [GEN_W-1:0] g, int unsigned b);
    return g == m_gen && b < m_bounds;
  endfunction

  function automatic bit bound_on(logic [GEN_W-1:0] g, int unsigned b);
    if (bound_known(g, b) && m_member[b]) return 1;
    return m_pend_v && g == m_gen && m_pend_b == b;
  endfunction

  // Apply one item to the model and return the result it produces
  function automatic res_t trail_apply(item_t it);
    res_t r;
    bit own;
    int lv;
    bit found;
    r = '0;
    r.status = ST_OK;
    own = (it.gen == m_gen);
    case (it.command)
      CMD_REG_BOUND: begin
        if (!own) r.status = ST_INVALID;
        else if (m_bounds >= N_BOUNDS) r.status = ST_FULL;
        else if (it.bidx != m_bounds) r.status = ST_INVALID;
        else begin
          m_member[m_bounds] = 0;
          m_bounds++;
        end
      end
      CMD_REG_ATOM: begin
        if (!own) r.status = ST_INVALID;
        else if (m_atoms >= N_ATOMS) r.status = ST_FULL;
        else if (it.aidx != m_atoms) r.status = ST_INVALID;
        else begin
          m_apos[m_atoms] = it.pos;
          m_aneg[m_atoms] = it.neg;
          m_atoms++;
        end
      end
      CMD_PUSH: begin
        if (!own || it.ckpt == 0) r.status = ST_BAD_CKPT;
        else if (m_levels >= N_LEVELS) r.status = ST_FULL;
        else begin
          m_ltag[m_levels] = it.ckpt;
          m_lmark[m_levels] = m_trail;
          m_levels++;
        end
      end
      CMD_ACTIVATE: begin
        if (!bound_known(it.gen, it.bidx) || bound_on(it.gen, it.bidx)) r.status = ST_INVALID;
        else if (m_trail >= N_BOUNDS) r.status = ST_FULL;
        else begin
          m_trail_ent[m_trail] = it.bidx;
          m_trail++;
          m_member[it.bidx] = 1;
        end
      end
      CMD_POP: begin
        lv = m_levels;
        found = 0;
        if (own) begin
          while (lv > 0 && !found) begin
            lv--;
            if (m_ltag[lv] == it.ckpt) found = 1;
          end
        end
        if (!found) r.status = ST_BAD_CKPT;
        else begin
          for (int i = m_lmark[lv]; i < m_trail; i++) m_member[m_trail_ent[i]] = 0;
          if (m_lmark[lv] < m_trail) m_trail = m_lmark[lv];
          m_levels = lv;
          m_pend_v = 0;
          m_pend_b = '0;
        end
      end
      CMD_SET_PENDING: begin
        if (!bound_known(it.gen, it.bidx) || bound_on(it.gen, it.bidx)) r.status = ST_INVALID;
        else begin
          m_pend_v = 1;
          m_pend_b = it.bidx;
        end
      end
      CMD_CLR_PENDING: begin
        m_pend_v = 0;
        m_pend_b = '0;
      end
      CMD_QUERY_BOUND: r.act = bound_on(it.gen, it.bidx);
      CMD_QUERY_ATOM: begin
        if (!own || it.aidx >= m_atoms) r.status = ST_INVALID;
        else if (bound_on(m_gen, m_apos[it.aidx])) begin
          r.known = 1;
          r.positive = 1;
        end else if (bound_on(m_gen, m_aneg[it.aidx])) r.known = 1;
      end
      default: r.status = ST_INVALID;
    endcase
    r.trail = TRAIL_CNT_W'(m_trail);
    r.levels = LEVEL_CNT_W'(m_levels);
    return r;
  endfunction

  function automatic item_t mk(cmd_e c, int g, int b, int a, int p, int n, int k);
    item_t it;
    it.command = c;
    it.gen = GEN_W'(g);
    it.bidx = BIDX_W'(b);
    it.aidx = AIDX_W'(a);
    it.pos = BIDX_W'(p);
    it.neg = BIDX_W'(n);
    it.ckpt = CKPT_W'(k);
    return it;
  endfunction

  function automatic res_t rs(status_e s, int t, int l);
    res_t r;
    r = '0;
    r.status = s;
    r.trail = TRAIL_CNT_W'(t);
    r.levels = LEVEL_CNT_W'(l);
    return r;
  endfunction

  // Append one directed row
  function automatic void add_row(item_t it, bit has_exp, res_t exp);
    row_t w;
    w.it = it;
    w.has_exp = has_exp;
    w.exp = exp;
    dir_tab.insert(dir_tab.size(), w);
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sink side: random stall, with a held-off stretch on request
  initial begin
    res_ch.ready = 0;
    forever begin
      @(posedge clk);
      res_ch.ready <= !hold_off && ($urandom_range(99) >= idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      res_t got, want;
      got.status = status_e'(res_ch.status);
      got.act = res_ch.bound_active;
      got.known = res_ch.polarity_known;
      got.positive = res_ch.polarity_positive;
      got.trail = res_ch.trail_count;
      got.levels = res_ch.level_total;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > STALL_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one item and wait for acceptance; prediction happens at the accepting edge.
  // Valid stays up after acceptance so the next item can follow without a gap.
  task automatic send_item(item_t it, bit has_exp, res_t exp);
    res_t pred;
    while ($urandom_range(99) < idle_pct) begin
      item_ch.valid <= 0;
      @(posedge clk);
    end
    item_ch.valid <= 1;
    item_ch.command <= it.command;
    item_ch.item_generation <= it.gen;
    item_ch.bound_index <= it.bidx;
    item_ch.atom_index <= it.aidx;
    item_ch.pos_lit_bound <= it.pos;
    item_ch.neg_lit_bound <= it.neg;
    item_ch.checkpoint_id <= it.ckpt;
    do @(posedge clk); while (!item_ch.ready);
    pred = trail_apply(it);
    if (has_exp && pred !== exp) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees: typed %p model %p", exp, pred);
    end
    expected_q.insert(expected_q.size(), has_exp ? exp : pred);
  endtask

  task automatic drain();
    item_ch.valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gen(logic [GEN_W-1:0] g);
    cfg_ch.valid <= 1;
    cfg_ch.data <= g;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    m_gen = g;
  endtask

  // Random item biased toward well-formed solver traffic
  function automatic item_t rand_item();
    item_t it;
    int sel;
    int nb;
    it = mk(CMD_QUERY_BOUND, m_gen, $urandom_range(1023), $urandom_range(511),
            $urandom_range(1023), $urandom_range(1023), $urandom_range(65535));
    nb = (m_bounds == 0) ? 1 : m_bounds;
    sel = $urandom_range(99);
    if (sel < 8) it.command = CMD_REG_BOUND;
    else if (sel < 14) it.command = CMD_REG_ATOM;
    else if (sel < 24) it.command = CMD_PUSH;
    else if (sel < 46) it.command = CMD_ACTIVATE;
    else if (sel < 56) it.command = CMD_POP;
    else if (sel < 63) it.command = CMD_SET_PENDING;
    else if (sel < 67) it.command = CMD_CLR_PENDING;
    else if (sel < 80) it.command = CMD_QUERY_BOUND;
    else if (sel < 94) it.command = CMD_QUERY_ATOM;
    else it.command = cmd_e'(CMD_W'($urandom_range(15)));
    if ($urandom_range(99) < 85) begin
      it.bidx = BIDX_W'((it.command == CMD_REG_BOUND) ? m_bounds : $urandom_range(nb - 1));
      it.aidx = AIDX_W'((it.command == CMD_REG_ATOM) ? m_atoms
              : $urandom_range(m_atoms == 0 ? 0 : m_atoms - 1));
      it.pos = BIDX_W'($urandom_range(nb - 1));
      it.neg = BIDX_W'($urandom_range(nb - 1));
      it.ckpt = CKPT_W'($urandom_range(1, 12));
      if (it.command == CMD_POP && m_levels != 0 && $urandom_range(1))
        it.ckpt = m_ltag[$urandom_range(m_levels - 1)];
    end
    if ($urandom_range(99) < 5) it.gen = GEN_W'($urandom_range(65535));
    return it;
  endfunction

  initial begin
    rst = 1;
    item_ch.valid = 0;
    item_ch.command = CMD_REG_BOUND;
    item_ch.item_generation = '0;
    item_ch.bound_index = '0;
    item_ch.atom_index = '0;
    item_ch.pos_lit_bound = '0;
    item_ch.neg_lit_bound = '0;
    item_ch.checkpoint_id = '0;
    cfg_ch.valid = 0;
    cfg_ch.data = '0;
    idle_pct = 33;
    hold_off = 0;
    mismatches = 0;
    timed_out = 0;
    m_gen = GEN_RESET;
    m_bounds = 0; m_atoms = 0; m_trail = 0; m_levels = 0;
    m_pend_v = 0; m_pend_b = '0;
    foreach (m_member[i]) m_member[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed table: typed expectations for obvious rows, model for the rest
    add_row(mk(CMD_QUERY_BOUND, 1, 0, 0, 0, 0, 0), 1, rs(ST_OK, 0, 0));
    add_row(mk(CMD_REG_BOUND, 1, 1, 0, 0, 0, 0), 1, rs(ST_INVALID, 0, 0));
    add_row(mk(CMD_REG_BOUND, 16'hFFFF, 0, 0, 0, 0, 0), 1, rs(ST_INVALID, 0, 0));
    add_row(mk(CMD_REG_BOUND, 1, 0, 0, 0, 0, 0), 1, rs(ST_OK, 0, 0));
    add_row(mk(CMD_REG_BOUND, 1, 1, 0, 0, 0, 0), 1, rs(ST_OK, 0, 0));
    add_row(mk(CMD_REG_ATOM, 1, 0, 0, 1, 0, 0), 1, rs(ST_OK, 0, 0));
    add_row(mk(CMD_REG_ATOM, 1, 0, 511, 1023, 1023, 0), 1, rs(ST_INVALID, 0, 0));
    add_row(mk(CMD_PUSH, 1, 0, 0, 0, 0, 0), 1, rs(ST_BAD_CKPT, 0, 0));
    add_row(mk(CMD_PUSH, 1, 0, 0, 0, 0, 16'hFFFF), 1, rs(ST_OK, 0, 1));
    add_row(mk(CMD_ACTIVATE, 1, 1, 0, 0, 0, 0), 1, rs(ST_OK, 1, 1));
    add_row(mk(CMD_ACTIVATE, 1, 1, 0, 0, 0, 0), 1, rs(ST_INVALID, 1, 1));
    add_row(mk(CMD_ACTIVATE, 1, 1023, 0, 0, 0, 0), 1, rs(ST_INVALID, 1, 1));
    add_row(mk(CMD_QUERY_ATOM, 1, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(CMD_SET_PENDING, 1, 0, 0, 0, 0, 0), 1, rs(ST_OK, 1, 1));
    add_row(mk(CMD_QUERY_BOUND, 1, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(CMD_QUERY_BOUND, 2, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(CMD_ACTIVATE, 1, 0, 0, 0, 0, 0), 1, rs(ST_INVALID, 1, 1));
    add_row(mk(CMD_POP, 1, 0, 0, 0, 0, 5), 1, rs(ST_BAD_CKPT, 1, 1));
    add_row(mk(CMD_POP, 1, 0, 0, 0, 0, 16'hFFFF), 1, rs(ST_OK, 0, 0));
    add_row(mk(CMD_QUERY_ATOM, 1, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(CMD_QUERY_ATOM, 1, 0, 511, 0, 0, 0), 1, rs(ST_INVALID, 0, 0));
    add_row(mk(CMD_CLR_PENDING, 0, 0, 0, 0, 0, 0), 1, rs(ST_OK, 0, 0));
    add_row(mk(cmd_e'(4'hF), 1, 1023, 511, 1023, 1023, 16'hFFFF), 1,
            rs(ST_INVALID, 0, 0));
    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].has_exp, dir_tab[i].exp);
    drain();

    // Several generations, extremes included, with random traffic in each phase
    for (int ph = 0; ph < 4; ph++) begin
      write_gen(ph == 0 ? 16'h0000 : ph == 1 ? 16'hFFFF : ph == 2 ? 16'hA55A : 16'h0001);
      for (int j = 0; j < N_RANDOM / 4; j++) begin
        // quiet stretch with no idling, then a long receiver hold-off
        if (ph == 1 && j == 50) idle_pct = 0;
        if (ph == 1 && j == 200) idle_pct = 33;
        if (ph == 2 && j == 20) begin
          fork
            begin
              hold_off = 1;
              repeat (300) @(posedge clk);
              hold_off = 0;
            end
          join_none
        end
        send_item(rand_item(), 0, '0);
      end
      drain();
    end
    // Fill the level stack to capacity and overflow it
    for (int j = 0; j < N_LEVELS + 2; j++)
      send_item(mk(CMD_PUSH, m_gen, 0, 0, 0, 0, j + 1), 0, '0);
    send_item(mk(CMD_POP, m_gen, 0, 0, 0, 0, 1), 0, '0);
    drain();

    if (mismatches == 0 && expected_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
